// ===== hdl/beacon_position_moving_average_defines.svh =====
// assertion macros shared by the beacon position checker
`ifndef BEACON_POSITION_MOVING_AVERAGE_DEFINES_SVH
`define BEACON_POSITION_MOVING_AVERAGE_DEFINES_SVH

// antecedent in one cycle implies consequent in the next, ignored in reset
`define BPMA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// consequent holds in the cycle after reset is applied
`define BPMA_ASSERT_AFTER_RESET(lbl, cons, msg) \
   lbl: assert property (@(posedge clock) reset |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/bpma_pkg.sv =====
// shared types, codes and constants of the beacon position moving average
package bpma_pkg;

   localparam int MAX_WINDOW_DEFAULT = 128;
   localparam int COORD_BITS_DEFAULT = 12;

   localparam int COUNT_W      = 24;
   localparam int AVG_W        = 13;
   localparam int RSP_DATA_W   = 16;
   localparam int CSR_ADDR_W   = 2;
   localparam int CSR_DATA_W   = 24;
   localparam int WIN_CFG_W    = 8;

   localparam logic [CSR_ADDR_W-1:0] CFG_WINDOW_LENGTH = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CFG_MIN_PIXELS    = 2'd1;

   localparam int WINDOW_RESET              = 16;
   localparam logic [COUNT_W-1:0] MIN_PIXELS_RESET = 24'd10;

   typedef enum logic [1:0] {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SUB,
      ST_ADD,
      ST_DIV_INIT,
      ST_DIV,
      ST_FIX,
      ST_OUT
   } state_type;

endpackage

// ===== hdl/beacon_position_moving_average.sv =====
// top level: beacon position moving average with iterative divider
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+----------------------------------------
//  req     | in  | req_tvalid/req_tready  | tuser: func; tdata: pixel_count,
//          |     |                        |   box_left, box_right
//  rsp     | out | rsp_tvalid/rsp_tready  | tuser: detected; tdata: avg_position
//  csr     | in  | csr_valid/csr_ready    | csr_addr: register index; csr_data
//
//  a position request only sets the pending flag; a frame report goes through
//  load and add while the ring is filling, and load, subtract and add once it is
//  full (through the one shared adder); with a request pending and the ring full,
//  the restoring divider on that same adder, a sign fix and the output state follow
//  reset clears the pointer, fill count, sum and flags, sets the default window and
//  minimum; the ring memory is not cleared, every entry is written before it is read
//  a result waiting on rsp does not stop the next transfer on req; only a
//  second result stalls in the output state until the first is taken
module beacon_position_moving_average #(
   parameter int MAX_WINDOW = bpma_pkg::MAX_WINDOW_DEFAULT,
   parameter int COORD_BITS = bpma_pkg::COORD_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // pixel_count, box_left, box_right from bit 0 up, zero padded
   input  logic [((bpma_pkg::COUNT_W + 2*COORD_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   // func
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // avg_position, zero padded
   output logic [bpma_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // detected
   output logic                               rsp_tuser,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bpma_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [bpma_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int SAMPLE_W = COORD_BITS + 2;             // signed half-pixel sample
   localparam int PTR_W    = $clog2(MAX_WINDOW);
   localparam int WIN_W    = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W    = SAMPLE_W + $clog2(MAX_WINDOW);
   localparam int ALU_W    = SUM_W + 1;
   localparam int CNT_W    = $clog2(SUM_W);
   localparam int AVG_W    = bpma_pkg::AVG_W;
   localparam int EXT_W    = (SUM_W > AVG_W) ? SUM_W : AVG_W;
   localparam int LEFT_LO  = bpma_pkg::COUNT_W;
   localparam int RIGHT_LO = bpma_pkg::COUNT_W + COORD_BITS;
   localparam int WIN_RST  = (bpma_pkg::WINDOW_RESET > MAX_WINDOW) ?
                             MAX_WINDOW : bpma_pkg::WINDOW_RESET;

   // payload fields of the request
   logic [bpma_pkg::COUNT_W-1:0] pixel_count;
   logic [COORD_BITS-1:0]        box_left;
   logic [COORD_BITS-1:0]        box_right;

   assign pixel_count = req_tdata[bpma_pkg::COUNT_W-1:0];
   assign box_left    = req_tdata[LEFT_LO +: COORD_BITS];
   assign box_right   = req_tdata[RIGHT_LO +: COORD_BITS];

   bpma_pkg::state_type state_ff, state_in;

   // per-item working registers
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic                       det_ff, det_in;
   logic [PTR_W-1:0]           slot_ff, slot_in;

   // filter state
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic [PTR_W-1:0]           wp_ff, wp_in;
   logic [WIN_W-1:0]           fill_ff, fill_in;
   logic                       full_ff, full_in;
   logic                       pending_ff, pending_in;

   // configuration
   logic [WIN_W-1:0]                window_ff, window_in;
   logic [bpma_pkg::COUNT_W-1:0]    minpix_ff, minpix_in;

   // divider
   logic [ALU_W-1:0]           rem_ff, rem_in;
   logic [SUM_W-1:0]           quo_ff, quo_in;
   logic                       neg_ff, neg_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;

   // output register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_det_ff, rsp_det_in;
   logic [AVG_W-1:0]           rsp_avg_ff, rsp_avg_in;

   // shared unit and memory hookup
   bpma_pkg::alu_op_type       alu_op;
   logic [ALU_W-1:0]           alu_a, alu_b, alu_res;
   logic                       mem_wr_en, mem_rd_en;
   logic [SAMPLE_W-1:0]        mem_rd_data;

   // helpers
   logic                       req_xfer, csr_xfer;
   logic [ALU_W-1:0]           rem_shift;
   logic [WIN_W-1:0]           slot_next;
   logic [WIN_W-1:0]           fill_next;

   bpma_alu #(
      .WIDTH (ALU_W)
   ) u_alu (
      .op  (alu_op),
      .a   (alu_a),
      .b   (alu_b),
      .res (alu_res)
   );

   bpma_ring #(
      .DEPTH  (MAX_WINDOW),
      .DATA_W (SAMPLE_W)
   ) u_ring (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .rd_en   (mem_rd_en),
      .addr    (slot_ff),
      .wr_data (sample_ff),
      .rd_data (mem_rd_data)
   );

   assign req_xfer   = req_tvalid && req_tready;
   assign csr_xfer   = csr_valid && csr_ready;
   assign req_tready = (state_ff == bpma_pkg::ST_IDLE);
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_det_ff;
   assign rsp_tdata  = bpma_pkg::RSP_DATA_W'(rsp_avg_ff);

   // one more remainder bit per divider step
   assign rem_shift  = {rem_ff[ALU_W-2:0], quo_ff[SUM_W-1]};
   assign slot_next  = WIN_W'(slot_ff) + WIN_W'(1);
   assign fill_next  = fill_ff + WIN_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bpma_pkg::ST_IDLE;
         sum_ff       <= '0;
         wp_ff        <= '0;
         fill_ff      <= '0;
         full_ff      <= 1'b0;
         pending_ff   <= 1'b0;
         window_ff    <= WIN_W'(WIN_RST);
         minpix_ff    <= bpma_pkg::MIN_PIXELS_RESET;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         full_ff      <= full_in;
         pending_ff   <= pending_in;
         window_ff    <= window_in;
         minpix_ff    <= minpix_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff  <= sample_in;
      det_ff     <= det_in;
      slot_ff    <= slot_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      neg_ff     <= neg_in;
      rsp_det_ff <= rsp_det_in;
      rsp_avg_ff <= rsp_avg_in;
   end

   always_comb begin
      state_in     = state_ff;
      sample_in    = sample_ff;
      det_in       = det_ff;
      slot_in      = slot_ff;
      sum_in       = sum_ff;
      wp_in        = wp_ff;
      fill_in      = fill_ff;
      full_in      = full_ff;
      pending_in   = pending_ff;
      window_in    = window_ff;
      minpix_in    = minpix_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      neg_in       = neg_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_det_in   = rsp_det_ff;
      rsp_avg_in   = rsp_avg_ff;
      alu_op       = bpma_pkg::ALU_ADD;
      alu_a        = ALU_W'(sum_ff);
      alu_b        = ALU_W'(sample_ff);
      mem_wr_en    = 1'b0;
      mem_rd_en    = 1'b0;

      case (state_ff)
         bpma_pkg::ST_IDLE: begin
            if (req_xfer) begin
               if (req_tuser) begin
                  pending_in = 1'b1;
               end else begin
                  det_in = pixel_count > minpix_ff;
                  // left + right is the centre in half pixels; no beacon is -1 pixel
                  sample_in = det_in ?
                              $signed(SAMPLE_W'(box_left) + SAMPLE_W'(box_right)) :
                              SAMPLE_W'(-2);
                  slot_in  = (WIN_W'(wp_ff) >= window_ff) ? '0 : wp_ff;
                  state_in = bpma_pkg::ST_LOAD;
               end
            end
         end
         bpma_pkg::ST_LOAD: begin
            // fetch the oldest sample; only needed once the ring is full
            mem_rd_en = full_ff;
            state_in  = full_ff ? bpma_pkg::ST_SUB : bpma_pkg::ST_ADD;
         end
         bpma_pkg::ST_SUB: begin
            alu_op   = bpma_pkg::ALU_SUB;
            alu_b    = ALU_W'($signed(mem_rd_data));
            sum_in   = alu_res[SUM_W-1:0];
            state_in = bpma_pkg::ST_ADD;
         end
         bpma_pkg::ST_ADD: begin
            sum_in    = alu_res[SUM_W-1:0];
            mem_wr_en = 1'b1;
            wp_in     = (slot_next >= window_ff) ? '0 : PTR_W'(slot_next);
            if (!full_ff) begin
               fill_in  = fill_next;
               full_in  = fill_next >= window_ff;
               state_in = bpma_pkg::ST_IDLE;
            end else begin
               state_in = pending_ff ? bpma_pkg::ST_DIV_INIT : bpma_pkg::ST_IDLE;
            end
         end
         bpma_pkg::ST_DIV_INIT: begin
            // divide the magnitude, restore the sign afterwards
            alu_op   = bpma_pkg::ALU_SUB;
            alu_a    = '0;
            alu_b    = ALU_W'(sum_ff);
            neg_in   = sum_ff[SUM_W-1];
            quo_in   = neg_in ? alu_res[SUM_W-1:0] : sum_ff;
            rem_in   = '0;
            cnt_in   = '0;
            state_in = bpma_pkg::ST_DIV;
         end
         bpma_pkg::ST_DIV: begin
            // restoring step, divisor is twice the window
            alu_op = bpma_pkg::ALU_SUB;
            alu_a  = rem_shift;
            alu_b  = ALU_W'({window_ff, 1'b0});
            if (alu_res[ALU_W-1]) begin
               rem_in = rem_shift;
               quo_in = {quo_ff[SUM_W-2:0], 1'b0};
            end else begin
               rem_in = alu_res;
               quo_in = {quo_ff[SUM_W-2:0], 1'b1};
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(SUM_W - 1)) begin
               state_in = bpma_pkg::ST_FIX;
            end
         end
         bpma_pkg::ST_FIX: begin
            alu_op   = bpma_pkg::ALU_SUB;
            alu_a    = '0;
            alu_b    = ALU_W'(quo_ff);
            quo_in   = neg_ff ? alu_res[SUM_W-1:0] : quo_ff;
            state_in = bpma_pkg::ST_OUT;
         end
         bpma_pkg::ST_OUT: begin
            // wait for the output register to be free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_det_in   = det_ff;
               rsp_avg_in   = AVG_W'(EXT_W'($signed(quo_ff)));
               pending_in   = 1'b0;
               state_in     = bpma_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bpma_pkg::ST_IDLE;
         end
      endcase

      // register writes; a window write restarts the fill
      if (csr_xfer) begin
         case (csr_addr)
            bpma_pkg::CFG_WINDOW_LENGTH: begin
               if (csr_data[bpma_pkg::WIN_CFG_W-1:0] == '0) begin
                  window_in = WIN_W'(1);
               end else if (32'(csr_data[bpma_pkg::WIN_CFG_W-1:0]) > 32'(MAX_WINDOW)) begin
                  window_in = WIN_W'(MAX_WINDOW);
               end else begin
                  window_in = WIN_W'(csr_data[bpma_pkg::WIN_CFG_W-1:0]);
               end
               sum_in  = '0;
               wp_in   = '0;
               fill_in = '0;
               full_in = 1'b0;
            end
            bpma_pkg::CFG_MIN_PIXELS: begin
               minpix_in = csr_data[bpma_pkg::COUNT_W-1:0];
            end
            default: begin
               minpix_in = minpix_ff;
            end
         endcase
      end
   end

endmodule

// ===== hdl/bpma_alu.sv =====
// shared adder/subtractor used by the ring update and the divider
module bpma_alu #(
   parameter int WIDTH = 22
) (
   input  bpma_pkg::alu_op_type op,
   input  logic [WIDTH-1:0]     a,
   input  logic [WIDTH-1:0]     b,
   output logic [WIDTH-1:0]     res
);

   always_comb begin
      case (op)
         bpma_pkg::ALU_ADD: res = a + b;
         bpma_pkg::ALU_SUB: res = a - b;
         default:           res = a + b;
      endcase
   end

endmodule

// ===== hdl/bpma_ring.sv =====
// sample ring memory, one port, registered read
module bpma_ring #(
   parameter int DEPTH  = 128,
   parameter int DATA_W = 14
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [DATA_W-1:0]        wr_data,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/bpma_checker.sv =====
// port-level checker for the beacon position moving average, with its bind
`include "beacon_position_moving_average_defines.svh"

module bpma_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [bpma_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tuser
);

   `BPMA_ASSERT_NEXT(rsp_hold_a, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "rsp changed while stalled")

   `BPMA_ASSERT_AFTER_RESET(rsp_reset_a, !rsp_tvalid, "rsp valid right after reset")

   `BPMA_ASSERT_NEXT(req_only_a, req_tvalid && req_tready && req_tuser && !rsp_tvalid,
      !rsp_tvalid, "position request produced a result")

   `BPMA_ASSERT_NEXT(frame_busy_a, req_tvalid && req_tready && !req_tuser,
      !req_tready, "ready right after a frame transfer")

endmodule

bind beacon_position_moving_average bpma_checker u_bpma_checker (.*);
